### design/nearest_center_assign_core_assert.svh
// ---------------------------------------------------------------------------
// Nearest-centre assignment: assertion macros
// Shared property wrappers for the port checker.
// ---------------------------------------------------------------------------
`ifndef NEAREST_CENTER_ASSIGN_CORE_ASSERT_SVH
`define NEAREST_CENTER_ASSIGN_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset
`define NCA_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset
`define NCA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/nca_pkg.sv
// ---------------------------------------------------------------------------
// Nearest-centre assignment: shared package
// Sizes, codes, sequencer states and the pipeline tag word.
// ---------------------------------------------------------------------------
`default_nettype none

package nca_pkg;

   localparam int MAX_CENTERS = 64;
   localparam int MAX_DIMS    = 3;
   localparam int AXES        = 3;

   localparam int CENTER_ADDR_W = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
   localparam int COUNT_W       = $clog2(MAX_CENTERS + 1);

   localparam int SLOT_W        = 6;
   localparam int COORD_W       = 16;
   localparam int CENTER_W      = AXES * COORD_W;
   localparam int MAG_W         = COORD_W;
   localparam int SQ_W          = 2 * MAG_W;
   localparam int DIST_W        = 34;
   localparam int IDX_OUT_W     = 6;
   localparam int NUM_CENTERS_W = 7;
   localparam int NUM_DIMS_W    = 2;
   localparam int CSR_IDX_W     = 1;
   localparam int CSR_DATA_W    = 7;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_POINT = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_CENTERS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_DIMS    = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_REPORT
   } state_type;

   typedef struct packed {
      logic                     valid;
      logic                     last;
      logic [CENTER_ADDR_W-1:0] idx;
   } tag_type;

endpackage

`default_nettype wire

### design/nearest_center_assign_core.sv
// ---------------------------------------------------------------------------
// Nearest-centre assignment core
// Holds a table of cluster centres and returns, for each point word, the
// index of the nearest active centre and the exact squared distance to it.
// ---------------------------------------------------------------------------
//
//   channel   ports                         handshake
//   -------   ---------------------------   ------------------------------
//   request   req_action .. req_coord_z     start high while busy low
//   response  rsp_nearest_center, rsp_sq..  rsp_strobe, one cycle, no stall
//   csr       csr_index, csr_wdata          csr_write_en, no wait
//
// A load word is written into the centre memory at the accepting edge and
// leaves busy low, so the next word may follow in the next cycle.
// A point word keeps busy high while it scans all K centres, K being the clamped centre
// count: one centre is read from the centre memory's registered read port per cycle and
// fed through the shared distance unit; the strobe comes in the last busy cycle.
// Synchronous reset clears the sequencer and sets num_centers to 1 and
// num_dims to 2; the centre memory is not cleared.
// The receiver cannot stall; the strobe is high for exactly one cycle and the result word holds until the next point.
// ---------------------------------------------------------------------------
`default_nettype none

module nearest_center_assign_core (
   input  logic                                   clock,
   input  logic                                   reset,
   // request
   input  logic                                   start,
   output logic                                   busy,
   input  logic                                   req_action,
   input  logic [nca_pkg::SLOT_W-1:0]             req_center_slot,
   input  logic signed [nca_pkg::COORD_W-1:0]     req_coord_x,
   input  logic signed [nca_pkg::COORD_W-1:0]     req_coord_y,
   input  logic signed [nca_pkg::COORD_W-1:0]     req_coord_z,
   // response
   output logic                                   rsp_strobe,
   output logic [nca_pkg::IDX_OUT_W-1:0]          rsp_nearest_center,
   output logic [nca_pkg::DIST_W-1:0]             rsp_squared_distance,
   // configuration
   input  logic                                   csr_write_en,
   input  logic [nca_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [nca_pkg::CSR_DATA_W-1:0]         csr_wdata
);

   // Configuration registers
   logic [nca_pkg::NUM_CENTERS_W-1:0] num_centers_in, num_centers_ff;
   logic [nca_pkg::NUM_DIMS_W-1:0]    num_dims_in, num_dims_ff;

   // Sequencer
   nca_pkg::state_type                state_in, state_ff;
   logic                              accept;
   logic                              point_go;
   logic                              load_we;
   logic                              issue_en;
   logic                              issue_last;
   logic [nca_pkg::COUNT_W-1:0]       issue_cnt_in, issue_cnt_ff;
   logic [nca_pkg::COUNT_W-1:0]       k_in, k_ff;
   logic [nca_pkg::NUM_DIMS_W-1:0]    dims_in, dims_ff;

   // Point held for the whole scan
   logic signed [nca_pkg::COORD_W-1:0] pt_x_ff, pt_y_ff, pt_z_ff;

   // Centre memory
   logic [nca_pkg::CENTER_W-1:0]      center_mem [nca_pkg::MAX_CENTERS];
   logic [nca_pkg::CENTER_ADDR_W-1:0] wr_addr;
   logic [nca_pkg::CENTER_ADDR_W-1:0] rd_addr;
   logic [nca_pkg::CENTER_W-1:0]      center_q_ff;
   nca_pkg::tag_type                  tag_s1_in, tag_s1_ff;

   // Distance unit result and running best
   logic [nca_pkg::DIST_W-1:0]        dist_s3;
   nca_pkg::tag_type                  tag_s3;
   logic                              best_take;
   logic [nca_pkg::CENTER_ADDR_W-1:0] best_idx_in, best_idx_ff;
   logic [nca_pkg::DIST_W-1:0]        best_dist_in, best_dist_ff;

   // ------------------------------------------------------------------
   // Configuration writes
   // ------------------------------------------------------------------
   always_comb begin
      num_centers_in = num_centers_ff;
      num_dims_in    = num_dims_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            nca_pkg::CSR_NUM_CENTERS: begin
               num_centers_in = csr_wdata[nca_pkg::NUM_CENTERS_W-1:0];
            end
            nca_pkg::CSR_NUM_DIMS: begin
               num_dims_in = csr_wdata[nca_pkg::NUM_DIMS_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_centers_ff <= nca_pkg::NUM_CENTERS_W'(1);
         num_dims_ff    <= nca_pkg::NUM_DIMS_W'(2);
      end else begin
         num_centers_ff <= num_centers_in;
         num_dims_ff    <= num_dims_in;
      end
   end

   // ------------------------------------------------------------------
   // Word acceptance and clamped scan limits
   // ------------------------------------------------------------------
   assign accept   = start && !busy;
   assign point_go = accept && (req_action == nca_pkg::ACT_POINT);
   // A slot beyond the table is dropped
   assign load_we  = accept && (req_action == nca_pkg::ACT_LOAD)
                     && (int'(req_center_slot) < nca_pkg::MAX_CENTERS);
   assign wr_addr  = nca_pkg::CENTER_ADDR_W'(req_center_slot);

   // Zero centres act as one; too many saturate at the table size
   always_comb begin
      if (num_centers_ff == '0) begin
         k_in = nca_pkg::COUNT_W'(1);
      end else if (int'(num_centers_ff) > nca_pkg::MAX_CENTERS) begin
         k_in = nca_pkg::COUNT_W'(nca_pkg::MAX_CENTERS);
      end else begin
         k_in = nca_pkg::COUNT_W'(num_centers_ff);
      end
      // Zero dimensions act as one; too many saturate
      if (num_dims_ff == '0) begin
         dims_in = nca_pkg::NUM_DIMS_W'(1);
      end else if (int'(num_dims_ff) > nca_pkg::MAX_DIMS) begin
         dims_in = nca_pkg::NUM_DIMS_W'(nca_pkg::MAX_DIMS);
      end else begin
         dims_in = num_dims_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (point_go) begin
         k_ff    <= k_in;
         dims_ff <= dims_in;
         pt_x_ff <= req_coord_x;
         pt_y_ff <= req_coord_y;
         pt_z_ff <= req_coord_z;
      end
   end

   // ------------------------------------------------------------------
   // Sequencer: next state
   // ------------------------------------------------------------------
   assign issue_last = (issue_cnt_ff == (k_ff - nca_pkg::COUNT_W'(1)));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         nca_pkg::ST_IDLE: begin
            if (point_go) state_in = nca_pkg::ST_SCAN;
         end
         nca_pkg::ST_SCAN: begin
            if (issue_last) state_in = nca_pkg::ST_DRAIN;
         end
         nca_pkg::ST_DRAIN: begin
            if (tag_s3.valid && tag_s3.last) state_in = nca_pkg::ST_REPORT;
         end
         nca_pkg::ST_REPORT: begin
            state_in = nca_pkg::ST_IDLE;
         end
         default: begin
            state_in = nca_pkg::ST_IDLE;
         end
      endcase
   end

   // Sequencer: outputs
   always_comb begin
      busy       = 1'b1;
      issue_en   = 1'b0;
      rsp_strobe = 1'b0;
      unique case (state_ff)
         nca_pkg::ST_IDLE:   busy       = 1'b0;
         nca_pkg::ST_SCAN:   issue_en   = 1'b1;
         nca_pkg::ST_DRAIN:  busy       = 1'b1;
         nca_pkg::ST_REPORT: rsp_strobe = 1'b1;
         default:            busy       = 1'b1;
      endcase
   end

   // Restart the centre counter on a new point, advance it while scanning
   always_comb begin
      issue_cnt_in = issue_cnt_ff;
      if (point_go) begin
         issue_cnt_in = '0;
      end else if (issue_en) begin
         issue_cnt_in = issue_cnt_ff + nca_pkg::COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nca_pkg::ST_IDLE;
         issue_cnt_ff <= '0;
      end else begin
         state_ff     <= state_in;
         issue_cnt_ff <= issue_cnt_in;
      end
   end

   // ------------------------------------------------------------------
   // Centre memory: one write port for loads, one registered read port
   // ------------------------------------------------------------------
   assign rd_addr = issue_cnt_ff[nca_pkg::CENTER_ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (load_we) begin
         center_mem[wr_addr] <= {req_coord_z, req_coord_y, req_coord_x};
      end
      center_q_ff <= center_mem[rd_addr];
   end

   // Tag travels alongside the read data
   always_comb begin
      tag_s1_in.valid = issue_en;
      tag_s1_in.last  = issue_last;
      tag_s1_in.idx   = rd_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_s1_ff <= '0;
      end else begin
         tag_s1_ff <= tag_s1_in;
      end
   end

   // ------------------------------------------------------------------
   // Shared distance unit
   // ------------------------------------------------------------------
   nca_dist_unit u_dist (
      .clock    (clock),
      .reset    (reset),
      .dims     (dims_ff),
      .pt_x     (pt_x_ff),
      .pt_y     (pt_y_ff),
      .pt_z     (pt_z_ff),
      .center   (center_q_ff),
      .tag_in   (tag_s1_ff),
      .dist_sum (dist_s3),
      .tag_out  (tag_s3)
   );

   // ------------------------------------------------------------------
   // Running minimum: the first centre always seeds it, later ones replace
   // it only when strictly nearer, so the lowest index wins a tie
   // ------------------------------------------------------------------
   assign best_take = tag_s3.valid
                      && ((tag_s3.idx == '0) || (dist_s3 < best_dist_ff));

   always_comb begin
      best_idx_in  = best_idx_ff;
      best_dist_in = best_dist_ff;
      if (best_take) begin
         best_idx_in  = tag_s3.idx;
         best_dist_in = dist_s3;
      end
   end

   always_ff @(posedge clock) begin
      best_idx_ff  <= best_idx_in;
      best_dist_ff <= best_dist_in;
   end

   // Result word: hold the best until the next point reseeds it
   assign rsp_nearest_center   = nca_pkg::IDX_OUT_W'(best_idx_ff);
   assign rsp_squared_distance = best_dist_ff;

endmodule

`default_nettype wire

### design/nca_dist_unit.sv
// ---------------------------------------------------------------------------
// Nearest-centre assignment: squared distance unit
// Two-stage pipe: per-axis squared differences, then their sum.
// ---------------------------------------------------------------------------
`default_nettype none

module nca_dist_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [nca_pkg::NUM_DIMS_W-1:0]      dims,
   input  logic signed [nca_pkg::COORD_W-1:0]  pt_x,
   input  logic signed [nca_pkg::COORD_W-1:0]  pt_y,
   input  logic signed [nca_pkg::COORD_W-1:0]  pt_z,
   input  logic [nca_pkg::CENTER_W-1:0]        center,
   input  nca_pkg::tag_type                    tag_in,
   output logic [nca_pkg::DIST_W-1:0]          dist_sum,
   output nca_pkg::tag_type                    tag_out
);

   logic signed [nca_pkg::COORD_W-1:0] pt_c  [nca_pkg::AXES];
   logic signed [nca_pkg::COORD_W-1:0] ctr_c [nca_pkg::AXES];
   logic signed [nca_pkg::COORD_W:0]   diff  [nca_pkg::AXES];
   logic        [nca_pkg::COORD_W:0]   neg   [nca_pkg::AXES];
   logic        [nca_pkg::MAG_W-1:0]   mag   [nca_pkg::AXES];
   logic        [nca_pkg::SQ_W-1:0]    sq_in [nca_pkg::AXES];
   logic        [nca_pkg::SQ_W-1:0]    sq_ff [nca_pkg::AXES];
   nca_pkg::tag_type                   tag_a_in, tag_a_ff;
   nca_pkg::tag_type                   tag_b_in, tag_b_ff;
   logic        [nca_pkg::DIST_W-1:0]  dist_in, dist_ff;

   // Stage A: difference, magnitude, square; drop inactive axes
   always_comb begin
      pt_c[0] = pt_x;
      pt_c[1] = pt_y;
      pt_c[2] = pt_z;
      for (int a = 0; a < nca_pkg::AXES; a++) begin
         ctr_c[a] = center[a*nca_pkg::COORD_W +: nca_pkg::COORD_W];
         diff[a]  = {pt_c[a][nca_pkg::COORD_W-1], pt_c[a]}
                  - {ctr_c[a][nca_pkg::COORD_W-1], ctr_c[a]};
         neg[a]   = -diff[a];
         mag[a]   = diff[a][nca_pkg::COORD_W] ? neg[a][nca_pkg::MAG_W-1:0]
                                               : diff[a][nca_pkg::MAG_W-1:0];
         if (a < int'(dims)) begin
            sq_in[a] = nca_pkg::SQ_W'(mag[a]) * nca_pkg::SQ_W'(mag[a]);
         end else begin
            sq_in[a] = '0;
         end
      end
      tag_a_in = tag_in;
   end

   // Stage B: sum of the squares
   always_comb begin
      dist_in  = nca_pkg::DIST_W'(sq_ff[0]) + nca_pkg::DIST_W'(sq_ff[1])
               + nca_pkg::DIST_W'(sq_ff[2]);
      tag_b_in = tag_a_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_a_ff <= '0;
         tag_b_ff <= '0;
      end else begin
         tag_a_ff <= tag_a_in;
         tag_b_ff <= tag_b_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < nca_pkg::AXES; a++) begin
         sq_ff[a] <= sq_in[a];
      end
      dist_ff <= dist_in;
   end

   assign dist_sum = dist_ff;
   assign tag_out  = tag_b_ff;

endmodule

`default_nettype wire

### design/nca_checker.sv
// ---------------------------------------------------------------------------
// Nearest-centre assignment: port checker
// Watches the top-level ports and flags sequencing slips.
// ---------------------------------------------------------------------------
`default_nettype none

`include "nearest_center_assign_core_assert.svh"

module nca_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_action,
   input logic rsp_strobe
);

   `NCA_ASSERT_NEXT(a_point_goes_busy, clock, reset, start && !busy && (req_action == nca_pkg::ACT_POINT), busy, "point word did not raise busy")
   `NCA_ASSERT_NEXT(a_load_stays_idle, clock, reset, start && !busy && (req_action == nca_pkg::ACT_LOAD), !busy && !rsp_strobe, "load word caused busy or a result")
   `NCA_ASSERT_SAME(a_strobe_in_busy, clock, reset, rsp_strobe, busy, "result strobe outside a busy period")
   `NCA_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe && !busy, "result strobe repeated or busy held")

endmodule

bind nearest_center_assign_core nca_checker u_nca_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_action (req_action),
   .rsp_strobe (rsp_strobe)
);

`default_nettype wire
